// ===== sv/lkpw_pkg.sv =====
`timescale 1ns / 1ps

package lkpw_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned LEN_IN_W = 7;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_ROTATE
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } state_t;

endpackage

// ===== sv/lkpw_cell.sv =====
`timescale 1ns / 1ps

module lkpw_cell
  import lkpw_pkg::*;
(
  input  logic              clk,
  input  cell_op_t          op,
  input  logic [DATA_W-1:0] shift_in,
  input  logic [DATA_W-1:0] rotate_in,
  output logic [DATA_W-1:0] value_out
);

  logic [DATA_W-1:0] value_r;
  logic [DATA_W-1:0] value_nxt;

  always_comb begin
    case (op)
      CELL_SHIFT:  value_nxt = shift_in;
      CELL_ROTATE: value_nxt = rotate_in;
      default:     value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value_out = value_r;

endmodule

// ===== sv/lkpw_ctrl.sv =====
`timescale 1ns / 1ps

module lkpw_ctrl
  import lkpw_pkg::*;
#(
  parameter int unsigned WINDOW = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_action,
  input  logic [LEN_IN_W-1:0]      in_window_len,
  input  logic [DATA_W-1:0]        head_value,
  output cell_op_t                 cell_op,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_product
);

  localparam int unsigned CNT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned COUNT_W = $clog2(WINDOW + 1);
  localparam int unsigned LEN_W   = (COUNT_W > LEN_IN_W) ? COUNT_W : LEN_IN_W;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    step_r, step_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [DATA_W-1:0]   acc_r, acc_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_product_r, out_product_nxt;
  logic [DATA_W-1:0]   prod_full;
  logic [LEN_W-1:0]    k_ext;
  logic [LEN_W-1:0]    count_ext;

  assign prod_full = acc_r * head_value;
  assign k_ext     = LEN_W'(in_window_len);
  assign count_ext = LEN_W'(count_r);

  always_comb begin
    state_nxt       = state_r;
    step_nxt        = step_r;
    count_nxt       = count_r;
    len_nxt         = len_r;
    acc_nxt         = acc_r;
    cell_op         = CELL_HOLD;
    out_valid_nxt   = out_valid_r && out_stall;
    out_product_nxt = out_product_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_QUERY) begin
            len_nxt   = (k_ext < count_ext) ? k_ext : count_ext;
            acc_nxt   = DATA_W'(1);
            step_nxt  = '0;
            state_nxt = ST_RUN;
          end else begin
            cell_op = CELL_SHIFT;
            if (count_r != COUNT_W'(WINDOW)) begin
              count_nxt = count_r + COUNT_W'(1);
            end
          end
        end
      end
      ST_RUN: begin
        cell_op = CELL_ROTATE;
        if (LEN_W'(step_r) < len_r) begin
          acc_nxt = prod_full;
        end
        step_nxt = step_r + CNT_W'(1);
        if (step_r == CNT_W'(WINDOW - 1)) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_product_nxt = acc_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r        <= step_nxt;
    len_r         <= len_nxt;
    acc_r         <= acc_nxt;
    out_product_r <= out_product_nxt;
  end

  assign in_stall    = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_product = $signed(out_product_r);

endmodule

// ===== sv/last_k_product_window.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Handshake          | Payload
// in_      | input     | in_valid/in_stall  | in_action, in_value, in_window_len
// out_     | output    | out_valid/out_stall| out_product
//
// An add transfer shifts the value into the head of the cell chain. A query holds
// in_stall high while the chain rotates once round all WINDOW cells, one multiply
// per cycle into the accumulator for the first min(k, count) steps, and until the
// result moves to the output register. Adds are taken while a result waits there.
// Synchronous active-low reset clears the stored count and the control state.
// A stalled output holds a finished query back in its final state.

module last_k_product_window
  import lkpw_pkg::*;
#(
  parameter int unsigned WINDOW = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_action,
  input  logic signed [DATA_W-1:0]   in_value,
  input  logic [LEN_IN_W-1:0]        in_window_len,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [DATA_W-1:0]   out_product
);

  cell_op_t          cell_op;
  logic [DATA_W-1:0] cell_val [WINDOW];
  logic [DATA_W-1:0] in_value_u;

  assign in_value_u = $unsigned(in_value);

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    lkpw_cell u_cell (
      .clk       (clk),
      .op        (cell_op),
      .shift_in  ((i == 0) ? in_value_u : cell_val[(i == 0) ? 0 : i - 1]),
      .rotate_in (cell_val[(i + 1) % WINDOW]),
      .value_out (cell_val[i])
    );
  end

  lkpw_ctrl #(
    .WINDOW (WINDOW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_window_len (in_window_len),
    .head_value    (cell_val[0]),
    .cell_op       (cell_op),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_product   (out_product)
  );

endmodule

// ===== sv/lkpw_checker.sv =====
`timescale 1ns / 1ps

module lkpw_checker
  import lkpw_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     in_action,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] out_product
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_product))
    else $error("stalled result changed or dropped");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_action == ACT_QUERY) |=> in_stall)
    else $error("input not held off after query transfer");

  a_add_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_action == ACT_ADD) |=> !in_stall)
    else $error("input held off after add transfer");

  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a query in progress");

endmodule

bind last_k_product_window lkpw_checker u_lkpw_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_action   (in_action),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_product (out_product)
);

// ===== test/tb_last_k_product_window.sv =====
`timescale 1ns / 1ps

import lkpw_pkg::*;

class window_product_tracker;
  localparam int unsigned DEPTH = 64;

  logic [DATA_W-1:0] history [DEPTH];
  int unsigned       head;
  int unsigned       held;
  logic [DATA_W-1:0] pending_products [$];
  int unsigned       errors;
  int unsigned       adds;
  int unsigned       products_checked;

  function new();
    head = 0;
    held = 0;
    errors = 0;
    adds = 0;
    products_checked = 0;
  endfunction

  // product of the newest min(k, held) values, wrapped to DATA_W bits
  function logic [DATA_W-1:0] expected_product(logic [LEN_IN_W-1:0] k);
    logic [DATA_W-1:0] acc;
    int unsigned       m;
    acc = 1;
    m = (k < held) ? k : held;
    for (int unsigned i = 0; i < m; i++) begin
      acc = acc * history[(head + DEPTH - 1 - i) % DEPTH];
    end
    return acc;
  endfunction

  function void note_transfer(logic act, logic [DATA_W-1:0] value, logic [LEN_IN_W-1:0] k);
    if (act == ACT_ADD) begin
      history[head] = value;
      head = (head + 1) % DEPTH;
      if (held < DEPTH) held++;
      adds++;
    end else begin
      pending_products.push_back(expected_product(k));
    end
  endfunction

  function void check_product(logic [DATA_W-1:0] got);
    logic [DATA_W-1:0] want;
    if (pending_products.size() == 0) begin
      $display("%0t: unexpected product %0d", $time, $signed(got));
      errors++;
      return;
    end
    want = pending_products.pop_front();
    products_checked++;
    if (got !== want) begin
      $display("%0t: product mismatch, expected %0d, got %0d", $time, $signed(want),
               $signed(got));
      errors++;
    end
  endfunction
endclass

module tb_last_k_product_window;
  localparam int unsigned WINDOW       = 64;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_action = ACT_ADD;
  logic signed [DATA_W-1:0] in_value = '0;
  logic [LEN_IN_W-1:0]      in_window_len = 7'd1;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_product;

  window_product_tracker tracker;
  int unsigned cycle_count = 0;
  bit          in_quiet = 1'b0;

  last_k_product_window #(.WINDOW(WINDOW)) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_value      (in_value),
    .in_window_len (in_window_len),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_product   (out_product)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_last_k_product_window NOT OK");
    $finish;
  end

  function automatic logic [DATA_W-1:0] draw_value();
    int unsigned r;
    logic [DATA_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 1) v = '0;
    else if (r < 6) v = 32'd1;
    else if (r < 11) v = 32'hFFFF_FFFF;
    else if (r < 14) v = 32'h7FFF_FFFF;
    else if (r < 17) v = 32'h8000_0000;
    else if (r < 45) v = $urandom | 32'd1;
    else if (r < 70) begin
      v = $urandom_range(2, 9);
      if ($urandom_range(0, 1)) v = -v;
    end else v = $urandom;
    return v;
  endfunction

  function automatic logic [LEN_IN_W-1:0] draw_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return LEN_IN_W'($urandom_range(1, 4));
    if (r < 55) return LEN_IN_W'(WINDOW);
    return LEN_IN_W'($urandom_range(1, WINDOW));
  endfunction

  task automatic send_item(logic act, logic [DATA_W-1:0] value, logic [LEN_IN_W-1:0] k);
    int unsigned gap;
    gap = in_quiet ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_value      <= value;
    in_window_len <= k;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.note_transfer(act, value, k);
  endtask

  // result side: random stall before each transfer, with quiet stretches
  initial begin
    int unsigned hold;
    wait (rst_n === 1'b1);
    forever begin
      hold = (((tracker.products_checked / 16) % 5) == 4) ? 0 : $urandom_range(0, 10);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      tracker.check_product(out_product);
    end
  end

  initial begin
    tracker = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty window, then extremes, sign wrap, ones and a zero
    send_item(ACT_QUERY, 32'h0, 7'd1);
    send_item(ACT_QUERY, 32'h0, 7'd64);
    send_item(ACT_ADD,   32'h7FFF_FFFF, 7'd1);
    send_item(ACT_QUERY, 32'h0, 7'd1);
    send_item(ACT_QUERY, 32'h0, 7'd64);
    send_item(ACT_ADD,   32'h8000_0000, 7'd64);
    send_item(ACT_QUERY, 32'h0, 7'd2);
    send_item(ACT_ADD,   32'hFFFF_FFFF, 7'd1);
    send_item(ACT_QUERY, 32'h0, 7'd1);
    send_item(ACT_QUERY, 32'h0, 7'd3);
    send_item(ACT_ADD,   32'd1, 7'd1);
    send_item(ACT_QUERY, 32'h0, 7'd2);
    send_item(ACT_ADD,   32'd0, 7'd1);
    send_item(ACT_QUERY, 32'h0, 7'd1);
    send_item(ACT_QUERY, 32'h0, 7'd64);
    send_item(ACT_ADD,   32'd3, 7'd1);
    send_item(ACT_QUERY, 32'h0, 7'd1);
    send_item(ACT_QUERY, 32'h0, 7'd2);
    send_item(ACT_QUERY, 32'hFFFF_FFFF, 7'h7F & 7'd64);
    send_item(ACT_ADD,   32'hFFFF_FFFE, 7'd64);

    // random stream; the add share keeps the ring wrapping past full
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      in_quiet = ((n / 64) % 5) == 4;
      if ($urandom_range(0, 99) < 62)
        send_item(ACT_ADD, draw_value(), LEN_IN_W'($urandom_range(1, WINDOW)));
      else
        send_item(ACT_QUERY, $urandom, draw_len());
    end
    in_valid <= 1'b0;

    while (tracker.pending_products.size() != 0) @(posedge clk);
    repeat (WINDOW + 8) @(posedge clk);
    if (tracker.pending_products.size() != 0) begin
      $display("%0t: %0d products never arrived", $time, tracker.pending_products.size());
      tracker.errors++;
    end

    $display("Stream of %0d values, %0d window products checked, %0d mismatches.",
             tracker.adds, tracker.products_checked, tracker.errors);
    if (tracker.errors == 0) begin
      $display("tb_last_k_product_window OK");
    end else begin
      $display("tb_last_k_product_window NOT OK");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/lkpw_pkg.sv
sv/lkpw_cell.sv
sv/lkpw_ctrl.sv
sv/last_k_product_window.sv
sv/lkpw_checker.sv
test/tb_last_k_product_window.sv
